@@ rtl/rgbconv_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbconv_pkg
// Shared types and constants for the streaming 3x3 RGB convolution filter:
// payload structs, register indexes, kernel codes and arithmetic constants.
// ----------------------------------------------------------------------------
package rgbconv_pkg;

	// Default line-buffer and frame limits
	localparam int MAX_WIDTH_DEF  = 4096;
	localparam int MAX_HEIGHT_DEF = 4096;

	// Field widths
	localparam int CHAN_W = 8;
	localparam int PIX_W  = 3 * CHAN_W;
	localparam int DIM_W  = 13;
	localparam int CNT_W  = 12;
	localparam int MODE_W = 2;
	localparam int IDX_W  = 2;
	localparam int CMP_W  = DIM_W + 1;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_EFFECT_MODE  = 2'd2;

	// Register reset values
	localparam logic [DIM_W-1:0]  WIDTH_RST  = 13'd640;
	localparam logic [DIM_W-1:0]  HEIGHT_RST = 13'd480;
	localparam logic [MODE_W-1:0] MODE_RST   = 2'd0;

	// Kernel codes
	localparam logic [MODE_W-1:0] MODE_IDENTITY = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BLUR     = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SHARPEN  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_EDGE     = 2'd3;

	// Smallest legal frame dimension
	localparam int MIN_DIM = 3;

	// floor(x/9) for x <= 2295 as (x * 7282) >> 16
	localparam int SUM_W      = 12;
	localparam int DIV9_MUL   = 7282;
	localparam int DIV9_W     = 13;
	localparam int DIV9_SHIFT = 16;

	typedef struct packed {
		logic [CHAN_W-1:0] in_red;
		logic [CHAN_W-1:0] in_green;
		logic [CHAN_W-1:0] in_blue;
	} pixel_in_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_red;
		logic [CHAN_W-1:0] out_green;
		logic [CHAN_W-1:0] out_blue;
		logic              frame_last;
	} pixel_out_t;

endpackage

@@ rtl/rgb_3x3_convolution_filter.sv @@
// ----------------------------------------------------------------------------
// rgb_3x3_convolution_filter
// Streaming 3x3 RGB filter with a packed two-row line buffer and a 3x3
// window; identity, box blur, sharpen or edge detect on each channel.
// ----------------------------------------------------------------------------
// Takes one pixel per clock in raster order while in_ready is high; border
// pixels (first two rows, first two columns) give no item, and every interior
// position yields one filtered pixel via stages 1 to 3 and the output register.
// The rate is set by the line buffer: a single memory of MAX_WIDTH words, each
// holding the pixels of the two previous rows for one column, is read once
// and written once per pixel. Set image_width, image_height and effect_mode
// only while the block is empty; sizes are clamped to 3..MAX_WIDTH and
// 3..MAX_HEIGHT. frame_last marks the last interior pixel of a frame.
module rgb_3x3_convolution_filter
	import rgbconv_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DIM_W-1:0]  cfg_data,
	// pixel input
	input  logic              in_valid,
	output logic              in_ready,
	input  pixel_in_t         in_data,
	// filtered output
	output logic              out_valid,
	input  logic              out_ready,
	output pixel_out_t        out_data
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	// configuration registers
	logic [DIM_W-1:0]  image_width_q;
	logic [DIM_W-1:0]  image_height_q;
	logic [MODE_W-1:0] effect_mode_q;

	// position counters
	logic [CNT_W-1:0] column_count_q;
	logic [CNT_W-1:0] row_count_q;

	// line buffer: [2*PIX_W-1:PIX_W] two rows above, [PIX_W-1:0] row above
	logic [2*PIX_W-1:0] row_store [MAX_WIDTH];
	logic [2*PIX_W-1:0] rd_s1;

	// stage 1: pixel waiting for its line-buffer data
	logic             v1_q;
	logic [PIX_W-1:0] px_s1;
	logic [AW-1:0]    addr_s1;
	logic             emit_s1;
	logic             last_s1;

	// stage 2: window holds a complete neighborhood
	logic [PIX_W-1:0] win_q [9];
	logic             v2_q;
	logic             last_s2;

	// stage 3: per-channel sums
	logic             v3_q;
	logic             last_s3;
	logic [SUM_W-1:0] sum9_s3   [3];
	logic [9:0]       cross_s3  [3];
	logic [CHAN_W-1:0] center_s3 [3];

	// output register
	logic       out_valid_q;
	pixel_out_t out_data_q;

	// flow control, each stage moves when the one after it has room
	logic rdy_o, rdy3, rdy2, rdy1;
	logic in_fire, s1_fire;

	assign rdy_o    = !out_valid_q || out_ready;
	assign rdy3     = !v3_q || rdy_o;
	assign rdy2     = !v2_q || rdy3;
	assign rdy1     = !v1_q || rdy2;
	assign in_ready = rdy1;
	assign in_fire  = in_valid && rdy1;
	assign s1_fire  = v1_q && rdy2;

	// configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_RST;
			image_height_q <= HEIGHT_RST;
			effect_mode_q  <= MODE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				REG_EFFECT_MODE:  effect_mode_q  <= cfg_data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// effective frame size and end-of-row / end-of-frame detection
	logic [CMP_W-1:0] w_eff, h_eff;
	logic             end_row, end_frame, emit;

	always_comb begin
		if (CMP_W'(image_width_q) < CMP_W'(MIN_DIM))
			w_eff = CMP_W'(MIN_DIM);
		else if (CMP_W'(image_width_q) > CMP_W'(MAX_WIDTH))
			w_eff = CMP_W'(MAX_WIDTH);
		else
			w_eff = CMP_W'(image_width_q);

		if (CMP_W'(image_height_q) < CMP_W'(MIN_DIM))
			h_eff = CMP_W'(MIN_DIM);
		else if (CMP_W'(image_height_q) > CMP_W'(MAX_HEIGHT))
			h_eff = CMP_W'(MAX_HEIGHT);
		else
			h_eff = CMP_W'(image_height_q);

		end_row   = (CMP_W'(column_count_q) + CMP_W'(1)) >= w_eff;
		end_frame = end_row && ((CMP_W'(row_count_q) + CMP_W'(1)) >= h_eff);
		emit      = (column_count_q >= CNT_W'(2)) && (row_count_q >= CNT_W'(2));
	end

	// position counters advance on every accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			row_count_q    <= '0;
		end else if (in_fire) begin
			if (end_row) begin
				column_count_q <= '0;
				row_count_q    <= end_frame ? '0 : row_count_q + CNT_W'(1);
			end else begin
				column_count_q <= column_count_q + CNT_W'(1);
			end
		end
	end

	// line buffer: read at accept, write back when the item leaves stage 1. Consecutive
	// items never share a column, so the write never meets a pending read.
	always_ff @(posedge clk) begin
		if (in_fire)
			rd_s1 <= row_store[AW'(column_count_q)];
		if (s1_fire)
			row_store[addr_s1] <= {rd_s1[PIX_W-1:0], px_s1};
	end

	// stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v1_q <= 1'b0;
		else if (rdy1)
			v1_q <= in_fire;
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			px_s1   <= in_data;
			addr_s1 <= AW'(column_count_q);
			emit_s1 <= emit;
			last_s1 <= end_frame;
		end
	end

	// window shift; only emitting items go on to stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++)
				win_q[i] <= '0;
			v2_q <= 1'b0;
		end else begin
			if (s1_fire) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r*3+0] <= win_q[r*3+1];
					win_q[r*3+1] <= win_q[r*3+2];
				end
				win_q[2] <= rd_s1[2*PIX_W-1:PIX_W];
				win_q[5] <= rd_s1[PIX_W-1:0];
				win_q[8] <= px_s1;
			end
			if (rdy2)
				v2_q <= v1_q && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire)
			last_s2 <= last_s1;
	end

	// stage 2 -> 3: nine-tap sum, four-neighbor sum and center per channel
	logic [SUM_W-1:0]  sum9_c   [3];
	logic [9:0]        cross_c  [3];
	logic [CHAN_W-1:0] center_c [3];

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			sum9_c[ch] = '0;
			for (int i = 0; i < 9; i++)
				sum9_c[ch] = sum9_c[ch] + SUM_W'(win_q[i][(2-ch)*CHAN_W +: CHAN_W]);
			cross_c[ch] = 10'(win_q[1][(2-ch)*CHAN_W +: CHAN_W])
				+ 10'(win_q[3][(2-ch)*CHAN_W +: CHAN_W])
				+ 10'(win_q[5][(2-ch)*CHAN_W +: CHAN_W])
				+ 10'(win_q[7][(2-ch)*CHAN_W +: CHAN_W]);
			center_c[ch] = win_q[4][(2-ch)*CHAN_W +: CHAN_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v3_q <= 1'b0;
		else if (rdy3)
			v3_q <= v2_q;
	end

	always_ff @(posedge clk) begin
		if (v2_q && rdy3) begin
			for (int ch = 0; ch < 3; ch++) begin
				sum9_s3[ch]   <= sum9_c[ch];
				cross_s3[ch]  <= cross_c[ch];
				center_s3[ch] <= center_c[ch];
			end
			last_s3 <= last_s2;
		end
	end

	// stage 3 -> out: kernel select and clamp to 0..255
	logic [CHAN_W-1:0] res_c [3];
	logic [SUM_W+DIV9_W-1:0] prod;
	logic signed [CMP_W-1:0] acc;

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			prod = (SUM_W+DIV9_W)'(sum9_s3[ch]) * (SUM_W+DIV9_W)'(DIV9_MUL);
			case (effect_mode_q)
				MODE_IDENTITY: acc = CMP_W'(center_s3[ch]);
				MODE_BLUR:     acc = CMP_W'(prod[DIV9_SHIFT +: CHAN_W]);
				MODE_SHARPEN:  acc = CMP_W'(center_s3[ch]) * CMP_W'(5)
				                     - CMP_W'(cross_s3[ch]);
				MODE_EDGE:     acc = CMP_W'(center_s3[ch]) * CMP_W'(9)
				                     - CMP_W'(sum9_s3[ch]);
				default:       acc = '0;
			endcase
			if (acc < 0)
				res_c[ch] = '0;
			else if (acc > CMP_W'(255))
				res_c[ch] = '1;
			else
				res_c[ch] = acc[CHAN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (rdy_o)
			out_valid_q <= v3_q;
	end

	always_ff @(posedge clk) begin
		if (v3_q && rdy_o) begin
			out_data_q.out_red    <= res_c[0];
			out_data_q.out_green  <= res_c[1];
			out_data_q.out_blue   <= res_c[2];
			out_data_q.frame_last <= last_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

@@ test/rgb_3x3_convolution_filter_tb.sv @@
// ----------------------------------------------------------------------------
// rgb_3x3_convolution_filter_tb
// Self-checking bench for the streaming 3x3 RGB filter. A clocked driver feeds
// queued pixels with random gaps, and a clocked monitor takes filtered pixels
// with random stalls. Each accepted pixel is run through a local line-buffer
// and window model, and every filtered pixel is compared field by field with
// the oldest predicted one. Covers the power-on sizes, the smallest frames,
// mid-frame resizing, clamping of out-of-range sizes and of channel sums,
// all four kernels, back-pressure and idle gaps.
// ----------------------------------------------------------------------------
module rgb_3x3_convolution_filter_tb;
	import rgbconv_pkg::*;

	localparam int CHAN_MAX       = 255;
	localparam int RANDOM_ITEMS   = 400;
	localparam int POWER_ON_ITEMS = 60;
	localparam int WIDE_ITEMS     = 50;
	localparam int TALL_ROWS      = 40;
	localparam int DRAIN_CYCLES   = 12;
	localparam int LONG_HOLD      = 300;
	localparam int CYCLE_LIMIT    = 1_000_000;
	localparam int PRINT_CAP      = 100;

	// Index with no register behind it; writes there must be ignored
	localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

	// Kernel used for the result of each directed row, from row 2 on
	localparam logic [MODE_W-1:0] ROW_MODES [6] = '{
		MODE_IDENTITY, MODE_BLUR, MODE_SHARPEN, MODE_EDGE, MODE_SHARPEN, MODE_EDGE
	};

	// DUT ports
	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [DIM_W-1:0] cfg_data  = '0;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	pixel_in_t        in_data   = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	pixel_out_t       out_data;

	rgb_3x3_convolution_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Filter model state
	logic [DIM_W-1:0]  cfg_width;
	logic [DIM_W-1:0]  cfg_height;
	logic [MODE_W-1:0] cfg_mode;
	logic [PIX_W-1:0]  line_mem [2*MAX_WIDTH_DEF];
	logic [PIX_W-1:0]  win [9];   // row*3+col, row 0 top, col 0 oldest
	int                col_cnt;
	int                row_cnt;

	// Stimulus and checking
	pixel_in_t  pixel_feed [$];
	pixel_out_t expected_pixels [$];
	int         in_gap_max    = 0;
	int         out_stall_max = 0;
	bit         hold_trigger  = 1'b0;
	int         feed_gap      = 0;
	int         rx_wait       = 0;
	int         rx_draw;
	int         hold_left     = 0;
	bit         hold_used     = 1'b0;
	int         fail_count      = 0;
	int         pixels_fed      = 0;
	int         results_checked = 0;
	int         cfg_writes      = 0;
	int         cycle_count     = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------- model

	function automatic int eff_width();
		if (cfg_width < MIN_DIM) return MIN_DIM;
		if (cfg_width > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
		return int'(cfg_width);
	endfunction

	function automatic int eff_height();
		if (cfg_height < MIN_DIM) return MIN_DIM;
		if (cfg_height > MAX_HEIGHT_DEF) return MAX_HEIGHT_DEF;
		return int'(cfg_height);
	endfunction

	function automatic void model_reset();
		cfg_width  = WIDTH_RST;
		cfg_height = HEIGHT_RST;
		cfg_mode   = MODE_RST;
		foreach (line_mem[i]) line_mem[i] = '0;
		foreach (win[i]) win[i] = '0;
		col_cnt = 0;
		row_cnt = 0;
	endfunction

	// Raster position step; a counter at or past the last position wraps
	function automatic void advance(inout int c, inout int r, input int w, input int h);
		if (c + 1 >= w) begin
			r = (r + 1 >= h) ? 0 : ((r + 1) & 12'hFFF);
			c = 0;
		end else begin
			c = (c + 1) & 12'hFFF;
		end
	endfunction

	// One channel of the window through the selected kernel, clamped
	function automatic logic [CHAN_W-1:0] convolve(input int sh);
		int tap [9];
		int acc;
		int i;
		for (i = 0; i < 9; i++) tap[i] = int'(win[i][sh +: CHAN_W]);
		acc = 0;
		case (cfg_mode)
			MODE_IDENTITY: acc = tap[4];
			MODE_BLUR: begin
				for (i = 0; i < 9; i++) acc += tap[i];
				acc = acc / 9;
			end
			MODE_SHARPEN: acc = 5 * tap[4] - tap[1] - tap[3] - tap[5] - tap[7];
			MODE_EDGE: begin
				for (i = 0; i < 9; i++) acc -= tap[i];
				acc += 9 * tap[4];
			end
		endcase
		if (acc < 0) acc = 0;
		if (acc > CHAN_MAX) acc = CHAN_MAX;
		return acc[CHAN_W-1:0];
	endfunction

	// Shift one accepted pixel into the window and line buffer
	function automatic void filter_pixel(input pixel_in_t px);
		int w;
		int h;
		int col;
		logic [PIX_W-1:0] above;
		logic [PIX_W-1:0] above2;
		pixel_out_t res;
		w = eff_width();
		h = eff_height();
		col = col_cnt % MAX_WIDTH_DEF;
		above  = line_mem[col];
		above2 = line_mem[MAX_WIDTH_DEF + col];
		for (int r = 0; r < 3; r++) begin
			win[r*3]   = win[r*3+1];
			win[r*3+1] = win[r*3+2];
		end
		win[2] = above2;
		win[5] = above;
		win[8] = px;
		line_mem[MAX_WIDTH_DEF + col] = above;
		line_mem[col] = px;
		// interior positions only
		if (col_cnt >= 2 && row_cnt >= 2) begin
			res.out_red    = convolve(16);
			res.out_green  = convolve(8);
			res.out_blue   = convolve(0);
			res.frame_last = (col_cnt + 1 >= w) && (row_cnt + 1 >= h);
			expected_pixels.push_back(res);
		end
		advance(col_cnt, row_cnt, w, h);
	endfunction

	// Pixels still needed to bring the counters back to the frame start
	function automatic int pixels_to_frame_end();
		int c;
		int r;
		int n;
		c = col_cnt;
		r = row_cnt;
		n = 0;
		do begin
			advance(c, r, eff_width(), eff_height());
			n++;
		end while (c != 0 || r != 0);
		return n;
	endfunction

	// ---------------------------------------------------------------- checks

	function automatic void report_field(input string field, input int want, input int got);
		fail_count++;
		if (fail_count <= PRINT_CAP)
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
	endfunction

	function automatic void check_pixel(input pixel_out_t got);
		pixel_out_t want;
		if (expected_pixels.size() == 0) begin
			fail_count++;
			if (fail_count <= PRINT_CAP)
				$display("%0t: filtered pixel with none expected: expected nothing, actual %h",
					$time, got);
			return;
		end
		want = expected_pixels.pop_front();
		results_checked++;
		if (got.out_red !== want.out_red)
			report_field("out_red", int'(want.out_red), int'(got.out_red));
		if (got.out_green !== want.out_green)
			report_field("out_green", int'(want.out_green), int'(got.out_green));
		if (got.out_blue !== want.out_blue)
			report_field("out_blue", int'(want.out_blue), int'(got.out_blue));
		if (got.frame_last !== want.frame_last)
			report_field("frame_last", int'(want.frame_last), int'(got.frame_last));
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	function automatic logic [CHAN_W-1:0] rand_chan();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return $urandom_range(0, CHAN_MAX);
		endcase
	endfunction

	// Queue n pixels; a flat run repeats one value to reach the sum extremes
	function automatic void feed_pixels(input int n, input bit flat);
		pixel_in_t px;
		px = {rand_chan(), rand_chan(), rand_chan()};
		for (int i = 0; i < n; i++) begin
			if (!flat) px = {rand_chan(), rand_chan(), rand_chan()};
			pixel_feed.push_back(px);
		end
	endfunction

	// Block drained: nothing queued, nothing offered, nothing expected
	task automatic wait_idle();
		do @(negedge clk);
		while (pixel_feed.size() != 0 || in_valid || expected_pixels.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Register write; the model follows at once since the block is idle
	task automatic write_reg(input logic [IDX_W-1:0] idx, input int value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[DIM_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_IMAGE_WIDTH:  cfg_width  = value[DIM_W-1:0];
			REG_IMAGE_HEIGHT: cfg_height = value[DIM_W-1:0];
			REG_EFFECT_MODE:  cfg_mode   = value[MODE_W-1:0];
			default: ;
		endcase
		cfg_writes++;
		@(negedge clk);
	endtask

	// ---------------------------------------------------------------- driver

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			feed_gap <= 0;
		end else begin
			if (in_valid && in_ready) begin
				filter_pixel(in_data);
				pixels_fed++;
			end
			// next item once the current one is gone
			if (!in_valid || in_ready) begin
				if (feed_gap != 0) begin
					in_valid <= 1'b0;
					feed_gap <= feed_gap - 1;
				end else if (pixel_feed.size() != 0) begin
					in_valid <= 1'b1;
					in_data  <= pixel_feed.pop_front();
					feed_gap <= $urandom_range(0, in_gap_max);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_wait   <= 0;
			hold_left <= 0;
			hold_used <= 1'b0;
		end else begin
			rx_draw = 0;
			if (out_valid && out_ready) begin
				check_pixel(out_data);
				rx_draw = $urandom_range(0, out_stall_max);
			end
			// one long hold-off on request, then per-item stalls
			if (hold_trigger && !hold_used) begin
				hold_used <= 1'b1;
				hold_left <= LONG_HOLD - 1;
				out_ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (rx_draw != 0) begin
				rx_wait   <= rx_draw - 1;
				out_ready <= 1'b0;
			end else if (rx_wait != 0) begin
				rx_wait   <= rx_wait - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- timeout

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
				cycle_count, expected_pixels.size());
			$display("** rgb_3x3_convolution_filter: FAILED **");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		pixel_in_t px;
		int random_fed;
		int phases;
		int w;
		int h;
		int n;
		random_fed = 0;
		phases = 0;
		model_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Power-on sizes and kernel: part of a 640-wide row, then shrink and end the frame
		feed_pixels(POWER_ON_ITEMS, 1'b0);
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, 4);
		write_reg(REG_IMAGE_HEIGHT, 3);
		feed_pixels(pixels_to_frame_end(), 1'b0);
		wait_idle();

		// Directed: narrowest frame (width below range), one kernel per result row
		write_reg(REG_IMAGE_WIDTH, 1);
		write_reg(REG_IMAGE_HEIGHT, 8);
		write_reg(REG_UNUSED, 13'h1ABC);
		for (int r = 0; r < 8; r++) begin
			if (r >= 2) begin
				wait_idle();
				write_reg(REG_EFFECT_MODE, int'(ROW_MODES[r-2]));
			end
			// checkerboards drive sharpen and edge sums past both clamps
			for (int c = 0; c < 3; c++) begin
				px.in_red   = ((r + c) % 2) ? 8'hFF : 8'h00;
				px.in_green = ((r + c) % 2) ? 8'h55 : 8'hAA;
				px.in_blue  = 8'((r * 3 + c) * 29);
				pixel_feed.push_back(px);
			end
		end
		wait_idle();

		// Sizes above and below range: part of one long row, then a short frame
		write_reg(REG_IMAGE_WIDTH, 13'h1FFF);
		write_reg(REG_IMAGE_HEIGHT, 0);
		write_reg(REG_EFFECT_MODE, MODE_BLUR);
		feed_pixels(WIDE_ITEMS, 1'b0);
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, 3);
		feed_pixels(pixels_to_frame_end(), 1'b0);
		wait_idle();

		// Taller frame at the narrowest width
		write_reg(REG_IMAGE_WIDTH, 3);
		write_reg(REG_IMAGE_HEIGHT, TALL_ROWS);
		write_reg(REG_EFFECT_MODE, MODE_EDGE);
		feed_pixels(3 * TALL_ROWS, 1'b0);
		wait_idle();

		// Resize mid-frame so both counters are already past the new last position
		write_reg(REG_IMAGE_WIDTH, 5);
		write_reg(REG_IMAGE_HEIGHT, 13'h1FFF);
		write_reg(REG_EFFECT_MODE, MODE_SHARPEN);
		feed_pixels(5 * 12 + 4, 1'b0);
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, 3);
		write_reg(REG_IMAGE_HEIGHT, 9);
		feed_pixels(pixels_to_frame_end() + 27, 1'b0);
		wait_idle();

		// Back-pressure: receiver holds off while the sender keeps offering
		in_gap_max = 0;
		out_stall_max = 0;
		write_reg(REG_IMAGE_WIDTH, 8);
		write_reg(REG_IMAGE_HEIGHT, 8);
		write_reg(REG_EFFECT_MODE, MODE_SHARPEN);
		hold_trigger = 1'b1;
		feed_pixels(64, 1'b0);
		wait_idle();

		// Random phases: mostly whole frames, some left unfinished
		while (random_fed < RANDOM_ITEMS) begin
			phases++;
			in_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : 7;
			out_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
			if ($urandom_range(0, 1))
				write_reg(REG_EFFECT_MODE, $urandom_range(0, 3) | ($urandom & 13'h1FFC));
			else
				write_reg(REG_EFFECT_MODE, $urandom_range(0, 3));
			if (col_cnt == 0 && row_cnt == 0) begin
				case ($urandom_range(0, 7))
					0: w = $urandom_range(0, MIN_DIM - 1);
					1: w = $urandom_range(13, 40);
					default: w = $urandom_range(MIN_DIM, 12);
				endcase
				write_reg(REG_IMAGE_WIDTH, w);
			end else if ($urandom_range(0, 1)) begin
				// mid-frame the width may only shrink, so no unwritten column is read
				write_reg(REG_IMAGE_WIDTH, $urandom_range(MIN_DIM, eff_width()));
			end
			if ($urandom_range(0, 7) == 0)
				h = $urandom_range(0, MIN_DIM - 1);
			else
				h = $urandom_range(MIN_DIM, (eff_width() > 12) ? 3 : 6);
			write_reg(REG_IMAGE_HEIGHT, h);
			n = 0;
			if (col_cnt != 0 || row_cnt != 0) n = pixels_to_frame_end();
			n += $urandom_range(1, 2) * eff_width() * eff_height();
			if ($urandom_range(0, 3) == 0)
				n += $urandom_range(1, eff_width() * eff_height() - 1);
			feed_pixels(n, $urandom_range(0, 7) == 0);
			random_fed += n;
			wait_idle();
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_pixels.size() != 0) begin
			fail_count++;
			$display("%0t: %0d filtered pixels never arrived: expected %0d more, actual 0",
				$time, expected_pixels.size(), expected_pixels.size());
		end
		$display("Fed %0d pixels, checked %0d filtered pixels, %0d register writes,",
			pixels_fed, results_checked, cfg_writes);
		$display("all four kernels, clamped and resized frames, %0d random phases, %0d failures.",
			phases, fail_count);
		if (fail_count == 0) begin
			$display("** rgb_3x3_convolution_filter: PASSED **");
		end else begin
			$display("** rgb_3x3_convolution_filter: FAILED **");
		end
		$finish;
	end

endmodule
